FILE: design/bcw_pkg.sv
`default_nettype none
package bcw_pkg;

    // field widths
    localparam int BAUD_W     = 24;
    localparam int CLK_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int STEP_W     = 12;
    localparam int LIMIT_W    = 16;
    localparam int WORD_W     = 32;

    // arithmetic width of the gcd and divider datapath
    localparam int DP_W       = 32;
    localparam int OVS_SHIFT  = 4;   // 16x oversampling
    localparam int LIMIT_POS  = 16;  // limit placed from this bit up in the control word

    localparam int S_TDATA_W  = ((BAUD_W + CLK_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STATUS_W + STEP_W + LIMIT_W + WORD_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int LIMIT_BITS_DEF = 16;
    localparam int STEP_BITS_DEF  = 12;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STAT_OK    = 3'd0;
    localparam status_t STAT_SLOW  = 3'd1;
    localparam status_t STAT_LIMIT = 3'd2;
    localparam status_t STAT_STEP  = 3'd3;
    localparam status_t STAT_ZERO  = 3'd4;

endpackage
`default_nettype wire

FILE: design/bcw_gcd.sv
`default_nettype none
// Binary gcd, one step per cycle. Common factors of two are stripped from
// the two inputs and, in step, from copies of them, so that at the end the
// copies divided by the odd part of the gcd give the exact quotients.
module bcw_gcd (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       start,
    input  wire [bcw_pkg::DP_W-1:0]   a_in,
    input  wire [bcw_pkg::DP_W-1:0]   b_in,
    output logic                      done,
    output logic [bcw_pkg::DP_W-1:0]  g_odd,
    output logic [bcw_pkg::DP_W-1:0]  a_red,
    output logic [bcw_pkg::DP_W-1:0]  b_red
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [bcw_pkg::DP_W-1:0] a_reg, a_next;
    logic [bcw_pkg::DP_W-1:0] b_reg, b_next;
    logic [bcw_pkg::DP_W-1:0] ax_reg, ax_next;
    logic [bcw_pkg::DP_W-1:0] bx_reg, bx_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        ax_next   = ax_reg;
        bx_next   = bx_reg;
        if (start) begin
            busy_next = 1'b1;
            a_next    = a_in;
            b_next    = b_in;
            ax_next   = a_in;
            bx_next   = b_in;
        end else if (busy_reg) begin
            if (!a_reg[0] && !b_reg[0]) begin
                a_next  = a_reg >> 1;
                b_next  = b_reg >> 1;
                ax_next = ax_reg >> 1;
                bx_next = bx_reg >> 1;
            end else if (!a_reg[0]) begin
                a_next = a_reg >> 1;
            end else if (!b_reg[0]) begin
                b_next = b_reg >> 1;
            end else if (a_reg == b_reg) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (a_reg > b_reg) begin
                a_next = a_reg - b_reg;
            end else begin
                b_next = b_reg - a_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg  <= a_next;
        b_reg  <= b_next;
        ax_reg <= ax_next;
        bx_reg <= bx_next;
    end

    assign done  = done_reg;
    assign g_odd = a_reg;
    assign a_red = ax_reg;
    assign b_red = bx_reg;

endmodule
`default_nettype wire

FILE: design/bcw_div.sv
`default_nettype none
// Restoring radix-2 divider, one quotient bit per cycle.
module bcw_div (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       start,
    input  wire [bcw_pkg::DP_W-1:0]   dividend,
    input  wire [bcw_pkg::DP_W-1:0]   divisor,
    output logic                      done,
    output logic [bcw_pkg::DP_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(bcw_pkg::DP_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(bcw_pkg::DP_W - 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [bcw_pkg::DP_W-1:0] quo_reg, quo_next;
    logic [bcw_pkg::DP_W-1:0] rem_reg, rem_next;
    logic [bcw_pkg::DP_W-1:0] dvs_reg, dvs_next;
    logic [bcw_pkg::DP_W:0]   trial;
    logic [bcw_pkg::DP_W:0]   diff;

    assign trial = {rem_reg, quo_reg[bcw_pkg::DP_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // dividend bits leave at the top, quotient bits enter at the bottom
            if (!diff[bcw_pkg::DP_W]) begin
                rem_next = diff[bcw_pkg::DP_W-1:0];
                quo_next = {quo_reg[bcw_pkg::DP_W-2:0], 1'b1};
            end else begin
                rem_next = trial[bcw_pkg::DP_W-1:0];
                quo_next = {quo_reg[bcw_pkg::DP_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

FILE: design/baud_control_word_calc.sv
`default_nettype none
// Channel  | Dir | tdata fields, low bit first             | tuser | tlast
// ---------+-----+-------------------------------------------+-------+------
// s_       | in  | baud[23:0], clock_hz[55:24]               |  -    |  -
// m_       | out | status, step_value, limit_value, ctl word |  -    |  -
//
// One word at a time. A word with a zero field skips the gcd and the divider and goes
// straight to the done state. Otherwise the binary gcd runs its shift and subtract steps,
// then the serial divider runs twice, once for 16*baud/g and once for clock/g.
// Reset is synchronous, active low, and clears the control state only.
// A new word is taken while the previous result waits in the output register;
// a finished result waits in the done state until that register frees up.
module baud_control_word_calc #(
    parameter int LIMIT_BITS = bcw_pkg::LIMIT_BITS_DEF,
    parameter int STEP_BITS  = bcw_pkg::STEP_BITS_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // baud [23:0], clock_hz [55:24]
    input  wire [bcw_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // status [2:0], step_value [14:3], limit_value [30:15], control_word [62:31]
    output logic [bcw_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GCD  = 3'd1;
    localparam logic [2:0] ST_DIVS = 3'd2;
    localparam logic [2:0] ST_DIVQ = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam int DP_W = bcw_pkg::DP_W;

    logic [2:0]                  state_reg, state_next;
    logic                        zero_reg, zero_next;
    logic [DP_W-1:0]             s_res_reg, s_res_next;
    logic [DP_W-1:0]             q_res_reg, q_res_next;

    logic                        m_valid_reg, m_valid_next;
    bcw_pkg::status_t            status_reg, status_next;
    logic [bcw_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [bcw_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic [bcw_pkg::WORD_W-1:0]  word_reg, word_next;

    logic [bcw_pkg::BAUD_W-1:0]  in_baud;
    logic [bcw_pkg::CLK_W-1:0]   in_clk;
    logic                        in_fire;
    logic                        in_zero;
    logic                        out_free;

    logic                        gcd_start, gcd_done;
    logic [DP_W-1:0]             gcd_a, gcd_g, gcd_ar, gcd_br;
    logic                        div_start, div_done;
    logic [DP_W-1:0]             div_dividend, div_quo;

    logic [DP_W-1:0]             lim_full;
    logic                        slow, lim_bad, step_bad;

    assign in_baud  = s_tdata[bcw_pkg::BAUD_W-1:0];
    assign in_clk   = s_tdata[bcw_pkg::BAUD_W +: bcw_pkg::CLK_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign in_zero  = (in_baud == '0) || (in_clk == '0);
    assign out_free = !m_valid_reg || m_tready;

    assign gcd_a     = {{(DP_W - bcw_pkg::BAUD_W - bcw_pkg::OVS_SHIFT){1'b0}},
                        in_baud, {bcw_pkg::OVS_SHIFT{1'b0}}};
    assign gcd_start = in_fire && !in_zero;

    bcw_gcd u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gcd_start),
        .a_in    (gcd_a),
        .b_in    (DP_W'(in_clk)),
        .done    (gcd_done),
        .g_odd   (gcd_g),
        .a_red   (gcd_ar),
        .b_red   (gcd_br)
    );

    assign div_start    = ((state_reg == ST_GCD) && gcd_done) ||
                          ((state_reg == ST_DIVS) && div_done);
    assign div_dividend = (state_reg == ST_GCD) ? gcd_ar : gcd_br;

    bcw_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (gcd_g),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign lim_full = q_res_reg - s_res_reg;
    assign slow     = (q_res_reg < s_res_reg);
    assign lim_bad  = (lim_full >> LIMIT_BITS) != '0;
    assign step_bad = (s_res_reg >> STEP_BITS) != '0;

    always_comb begin
        state_next   = state_reg;
        zero_next    = zero_reg;
        s_res_next   = s_res_reg;
        q_res_next   = q_res_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        step_next    = step_reg;
        limit_next   = limit_reg;
        word_next    = word_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    zero_next  = in_zero;
                    state_next = in_zero ? ST_DONE : ST_GCD;
                end
            end
            ST_GCD: begin
                if (gcd_done) begin
                    state_next = ST_DIVS;
                end
            end
            ST_DIVS: begin
                if (div_done) begin
                    s_res_next = div_quo;
                    state_next = ST_DIVQ;
                end
            end
            ST_DIVQ: begin
                if (div_done) begin
                    q_res_next = div_quo;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    step_next    = '0;
                    limit_next   = '0;
                    word_next    = '0;
                    if (zero_reg) begin
                        status_next = bcw_pkg::STAT_ZERO;
                    end else if (slow) begin
                        status_next = bcw_pkg::STAT_SLOW;
                    end else if (lim_bad) begin
                        status_next = bcw_pkg::STAT_LIMIT;
                    end else if (step_bad) begin
                        status_next = bcw_pkg::STAT_STEP;
                    end else begin
                        status_next = bcw_pkg::STAT_OK;
                        step_next   = s_res_reg[bcw_pkg::STEP_W-1:0];
                        limit_next  = lim_full[bcw_pkg::LIMIT_W-1:0];
                        // limit above, step below; step may reach into the limit field
                        word_next   = {lim_full[bcw_pkg::WORD_W-bcw_pkg::LIMIT_POS-1:0],
                                       {bcw_pkg::LIMIT_POS{1'b0}}}
                                      | s_res_reg[bcw_pkg::WORD_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        zero_reg   <= zero_next;
        s_res_reg  <= s_res_next;
        q_res_reg  <= q_res_next;
        status_reg <= status_next;
        step_reg   <= step_next;
        limit_reg  <= limit_next;
        word_reg   <= word_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(bcw_pkg::M_TDATA_W - bcw_pkg::M_FIELDS_W){1'b0}},
                       word_reg, limit_reg, step_reg, status_reg};

endmodule
`default_nettype wire
